[hw/rtl/wks_pkg.sv]
`default_nettype none
package wks_pkg;

    // Fixed field widths
    localparam int CMD_W    = 2;
    localparam int CHAR_W   = 8;
    localparam int WEIGHT_W = 24;
    localparam int TOTAL_W  = 40;

    // Default table geometry
    localparam int DEF_MAX_KEYWORDS = 64;
    localparam int DEF_MAX_WORD_LEN = 20;

    // Input command codes
    localparam logic [CMD_W-1:0] CMD_KEY_BYTE = 2'd0;
    localparam logic [CMD_W-1:0] CMD_COMMIT   = 2'd1;
    localparam logic [CMD_W-1:0] CMD_TEXT     = 2'd2;
    localparam logic [CMD_W-1:0] CMD_END      = 2'd3;

    // Word delimiters
    localparam logic [CHAR_W-1:0] CH_SPACE = 8'h20;
    localparam logic [CHAR_W-1:0] CH_LF    = 8'h0A;

    // Operations passed from front to back
    typedef logic [1:0] wks_kind_t;
    localparam wks_kind_t OP_COMMIT = 2'd0;
    localparam wks_kind_t OP_WORD   = 2'd1;
    localparam wks_kind_t OP_END    = 2'd2;

    typedef struct packed {
        wks_kind_t kind;
        logic      scan;
    } wks_op_t;

    localparam int OP_W = $bits(wks_op_t);

endpackage
`default_nettype wire

[hw/rtl/wks_front.sv]
`default_nettype none
module wks_front #(
    parameter int MAX_WORD_LEN = 20
) (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        item_valid,
    output logic                             item_ready,
    input  wire logic [wks_pkg::CMD_W-1:0]   command,
    input  wire logic [wks_pkg::CHAR_W-1:0]  char_byte,
    input  wire logic [wks_pkg::WEIGHT_W-1:0] weight,
    input  wire logic                        q_full,
    output logic                             q_push,
    output logic [wks_pkg::OP_W+wks_pkg::WEIGHT_W+$clog2(MAX_WORD_LEN+1)
                  +MAX_WORD_LEN*wks_pkg::CHAR_W-1:0] q_data
);
    import wks_pkg::*;

    localparam int LEN_W  = $clog2(MAX_WORD_LEN + 1);
    localparam int BIDX_W = (MAX_WORD_LEN > 1) ? $clog2(MAX_WORD_LEN) : 1;

    logic [MAX_WORD_LEN-1:0][CHAR_W-1:0] asm_chars_reg, asm_chars_next;
    logic [LEN_W-1:0]                    asm_len_reg, asm_len_next;
    logic                                asm_ovf_reg, asm_ovf_next;
    logic                                accept;
    logic                                has_room;
    logic                                is_delim;
    logic                                word_ok;
    wks_op_t                             op;

    assign item_ready = !q_full;
    assign accept     = item_valid && item_ready;
    assign has_room   = asm_len_reg < LEN_W'(MAX_WORD_LEN);
    assign is_delim   = (char_byte == CH_SPACE) || (char_byte == CH_LF);
    assign word_ok    = (asm_len_reg != '0) && !asm_ovf_reg;

    // Classify the word and update the assembly buffer
    always_comb
    begin
        asm_chars_next = asm_chars_reg;
        asm_len_next   = asm_len_reg;
        asm_ovf_next   = asm_ovf_reg;
        q_push         = 1'b0;
        op.kind        = OP_COMMIT;
        op.scan        = 1'b0;
        if (accept)
        begin
            case (command)
                CMD_KEY_BYTE:
                begin
                    if (has_room)
                    begin
                        asm_chars_next[asm_len_reg[BIDX_W-1:0]] = char_byte;
                        asm_len_next = asm_len_reg + LEN_W'(1);
                    end
                end
                CMD_COMMIT:
                begin
                    q_push       = 1'b1;
                    op.kind      = OP_COMMIT;
                    asm_len_next = '0;
                    asm_ovf_next = 1'b0;
                end
                CMD_TEXT:
                begin
                    if (is_delim)
                    begin
                        q_push       = word_ok;
                        op.kind      = OP_WORD;
                        op.scan      = 1'b1;
                        asm_len_next = '0;
                        asm_ovf_next = 1'b0;
                    end
                    else if (has_room)
                    begin
                        asm_chars_next[asm_len_reg[BIDX_W-1:0]] = char_byte;
                        asm_len_next = asm_len_reg + LEN_W'(1);
                    end
                    else
                    begin
                        asm_ovf_next = 1'b1;
                    end
                end
                default:
                begin
                    q_push       = 1'b1;
                    op.kind      = OP_END;
                    op.scan      = word_ok;
                    asm_len_next = '0;
                    asm_ovf_next = 1'b0;
                end
            endcase
        end
    end

    assign q_data = {op, weight, asm_len_reg, asm_chars_reg};

    // Hold assembly control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            asm_len_reg <= '0;
            asm_ovf_reg <= 1'b0;
        end
        else
        begin
            asm_len_reg <= asm_len_next;
            asm_ovf_reg <= asm_ovf_next;
        end
    end

    // Hold assembled bytes
    always_ff @(posedge clk)
    begin
        asm_chars_reg <= asm_chars_next;
    end

endmodule
`default_nettype wire

[hw/rtl/wks_queue.sv]
`default_nettype none
module wks_queue #(
    parameter int DATA_W = 8
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              push,
    input  wire logic [DATA_W-1:0] push_data,
    output logic                   full,
    input  wire logic              pop,
    output logic                   avail,
    output logic [DATA_W-1:0]      pop_data
);
    import wks_pkg::*;

    logic [DATA_W-1:0] slot_reg [2];
    logic              wr_ptr_reg, rd_ptr_reg;
    logic [1:0]        cnt_reg;
    logic              do_push, do_pop;

    assign full     = cnt_reg[1];
    assign avail    = cnt_reg != 2'd0;
    assign do_push  = push && !full;
    assign do_pop   = pop && avail;
    assign pop_data = slot_reg[rd_ptr_reg];

    // Advance pointers and occupancy
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end
        else
        begin
            if (do_push)
                wr_ptr_reg <= !wr_ptr_reg;
            if (do_pop)
                rd_ptr_reg <= !rd_ptr_reg;
            if (do_push && !do_pop)
                cnt_reg <= cnt_reg + 2'd1;
            else if (do_pop && !do_push)
                cnt_reg <= cnt_reg - 2'd1;
        end
    end

    // Store the pushed word
    always_ff @(posedge clk)
    begin
        if (do_push)
            slot_reg[wr_ptr_reg] <= push_data;
    end

endmodule
`default_nettype wire

[hw/rtl/wks_back.sv]
`default_nettype none
module wks_back #(
    parameter int MAX_KEYWORDS = 64,
    parameter int MAX_WORD_LEN = 20
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          q_avail,
    output logic                               q_pop,
    input  wire logic [wks_pkg::OP_W+wks_pkg::WEIGHT_W+$clog2(MAX_WORD_LEN+1)
                       +MAX_WORD_LEN*wks_pkg::CHAR_W-1:0] q_data,
    output logic                               result_valid,
    input  wire logic                          result_ready,
    output logic [wks_pkg::TOTAL_W-1:0]        total
);
    import wks_pkg::*;

    localparam int LEN_W   = $clog2(MAX_WORD_LEN + 1);
    localparam int WORD_W  = MAX_WORD_LEN * CHAR_W;
    localparam int ROW_W   = WEIGHT_W + LEN_W + WORD_W;
    localparam int COUNT_W = $clog2(MAX_KEYWORDS + 1);
    localparam int IDX_W   = (MAX_KEYWORDS > 1) ? $clog2(MAX_KEYWORDS) : 1;

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_SCAN = 2'd1;
    localparam logic [1:0] ST_EMIT = 2'd2;

    // Keyword table: one row per keyword
    logic [ROW_W-1:0] kw_mem [MAX_KEYWORDS];
    logic [ROW_W-1:0] row_reg;

    logic [1:0]          state_reg, state_next;
    logic [COUNT_W-1:0]  kw_count_reg, kw_count_next;
    logic [COUNT_W-1:0]  rd_idx_reg, rd_idx_next;
    logic                rd_pend_reg, rd_pend_next;
    logic                end_reg, end_next;
    logic [TOTAL_W-1:0]  total_reg, total_next;
    logic                out_valid_reg, out_valid_next;
    logic [TOTAL_W-1:0]  out_total_reg, out_total_next;
    logic [MAX_WORD_LEN-1:0][CHAR_W-1:0] word_reg, word_next;
    logic [LEN_W-1:0]    len_reg, len_next;

    wks_op_t                             q_op;
    logic [WEIGHT_W-1:0]                 q_weight;
    logic [LEN_W-1:0]                    q_len;
    logic [MAX_WORD_LEN-1:0][CHAR_W-1:0] q_chars;

    logic [MAX_WORD_LEN-1:0][CHAR_W-1:0] row_chars;
    logic [LEN_W-1:0]                    row_len;
    logic [WEIGHT_W-1:0]                 row_weight;
    logic                                bytes_eq;
    logic                                hit;
    logic                                more;
    logic                                issue;
    logic [TOTAL_W:0]                    sum;
    logic                                kw_we;
    logic                                out_free;

    assign {q_op, q_weight, q_len, q_chars} = q_data;
    assign row_chars  = row_reg[WORD_W-1:0];
    assign row_len    = row_reg[WORD_W +: LEN_W];
    assign row_weight = row_reg[WORD_W+LEN_W +: WEIGHT_W];

    // Compare the fetched keyword against the held word
    always_comb
    begin
        bytes_eq = 1'b1;
        for (int i = 0; i < MAX_WORD_LEN; i++)
        begin
            if ((LEN_W'(i) < len_reg) && (row_chars[i] != word_reg[i]))
                bytes_eq = 1'b0;
        end
    end

    assign hit   = rd_pend_reg && (row_len == len_reg) && bytes_eq;
    assign more  = rd_idx_reg < kw_count_reg;
    assign issue = (state_reg == ST_SCAN) && !hit && more;
    assign sum   = {1'b0, total_reg} + {{(TOTAL_W-WEIGHT_W+1){1'b0}}, row_weight};
    assign out_free = !out_valid_reg || result_ready;

    // Sequence operations from the queue
    always_comb
    begin
        state_next     = state_reg;
        kw_count_next  = kw_count_reg;
        rd_idx_next    = rd_idx_reg;
        rd_pend_next   = 1'b0;
        end_next       = end_reg;
        total_next     = total_reg;
        out_valid_next = out_valid_reg && !result_ready;
        out_total_next = out_total_reg;
        word_next      = word_reg;
        len_next       = len_reg;
        q_pop          = 1'b0;
        kw_we          = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                if (q_avail)
                begin
                    q_pop       = 1'b1;
                    word_next   = q_chars;
                    len_next    = q_len;
                    rd_idx_next = '0;
                    end_next    = q_op.kind == OP_END;
                    case (q_op.kind)
                        OP_COMMIT:
                        begin
                            if (kw_count_reg < COUNT_W'(MAX_KEYWORDS))
                            begin
                                kw_we         = 1'b1;
                                kw_count_next = kw_count_reg + COUNT_W'(1);
                            end
                        end
                        OP_WORD:
                            state_next = ST_SCAN;
                        OP_END:
                            state_next = q_op.scan ? ST_SCAN : ST_EMIT;
                        default:
                            state_next = ST_IDLE;
                    endcase
                end
            end
            ST_SCAN:
            begin
                rd_pend_next = issue;
                if (issue)
                    rd_idx_next = rd_idx_reg + COUNT_W'(1);
                if (hit)
                    total_next = sum[TOTAL_W] ? {TOTAL_W{1'b1}} : sum[TOTAL_W-1:0];
                if (hit || (!rd_pend_reg && !more))
                    state_next = end_reg ? ST_EMIT : ST_IDLE;
            end
            ST_EMIT:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_total_next = total_reg;
                    total_next     = '0;
                    state_next     = ST_IDLE;
                end
            end
            default:
                state_next = ST_IDLE;
        endcase
    end

    // Hold control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            kw_count_reg  <= '0;
            rd_idx_reg    <= '0;
            rd_pend_reg   <= 1'b0;
            end_reg       <= 1'b0;
            total_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            kw_count_reg  <= kw_count_next;
            rd_idx_reg    <= rd_idx_next;
            rd_pend_reg   <= rd_pend_next;
            end_reg       <= end_next;
            total_reg     <= total_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Hold payload
    always_ff @(posedge clk)
    begin
        out_total_reg <= out_total_next;
        word_reg      <= word_next;
        len_reg       <= len_next;
    end

    // Write and read the keyword table
    always_ff @(posedge clk)
    begin
        if (kw_we)
            kw_mem[kw_count_reg[IDX_W-1:0]] <= {q_weight, q_len, q_chars};
        row_reg <= kw_mem[rd_idx_reg[IDX_W-1:0]];
    end

    assign result_valid = out_valid_reg;
    assign total        = out_total_reg;

endmodule
`default_nettype wire

[hw/rtl/weighted_keyword_scorer_unit.sv]
`default_nettype none
// Channel   Direction  Handshake                   Word
// item      in         item_valid / item_ready     command, char_byte, weight
// result    out        result_valid / result_ready total
//
// The front takes one word per cycle while its two-entry queue has room.
// A commit is written to the table from the back end's idle state; a finished word scans the keyword
// table one row per cycle through its registered read port, stopping early on a match.
// An end word also passes through an emit state that loads the result register.
// Reset clears counts, total and queue; table rows need no clearing.
// A stalled result holds the back end; the queue then fills and drops item_ready.
module weighted_keyword_scorer_unit #(
    parameter int MAX_KEYWORDS = wks_pkg::DEF_MAX_KEYWORDS,
    parameter int MAX_WORD_LEN = wks_pkg::DEF_MAX_WORD_LEN
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          item_valid,
    output logic                               item_ready,
    input  wire logic [wks_pkg::CMD_W-1:0]     command,
    input  wire logic [wks_pkg::CHAR_W-1:0]    char_byte,
    input  wire logic [wks_pkg::WEIGHT_W-1:0]  weight,
    output logic                               result_valid,
    input  wire logic                          result_ready,
    output logic [wks_pkg::TOTAL_W-1:0]        total
);
    import wks_pkg::*;

    localparam int LEN_W  = $clog2(MAX_WORD_LEN + 1);
    localparam int DATA_W = OP_W + WEIGHT_W + LEN_W + MAX_WORD_LEN * CHAR_W;

    logic              q_full;
    logic              q_push;
    logic              q_pop;
    logic              q_avail;
    logic [DATA_W-1:0] q_push_data;
    logic [DATA_W-1:0] q_pop_data;

    wks_front #(
        .MAX_WORD_LEN (MAX_WORD_LEN)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .item_ready (item_ready),
        .command    (command),
        .char_byte  (char_byte),
        .weight     (weight),
        .q_full     (q_full),
        .q_push     (q_push),
        .q_data     (q_push_data)
    );

    wks_queue #(
        .DATA_W (DATA_W)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_data (q_push_data),
        .full      (q_full),
        .pop       (q_pop),
        .avail     (q_avail),
        .pop_data  (q_pop_data)
    );

    wks_back #(
        .MAX_KEYWORDS (MAX_KEYWORDS),
        .MAX_WORD_LEN (MAX_WORD_LEN)
    ) u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .q_avail      (q_avail),
        .q_pop        (q_pop),
        .q_data       (q_pop_data),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .total        (total)
    );

endmodule
`default_nettype wire

[tb/tb.sv]
`default_nettype none
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import wks_pkg::*;

    localparam int MAX_KEYWORDS    = DEF_MAX_KEYWORDS;
    localparam int MAX_WORD_LEN    = DEF_MAX_WORD_LEN;
    localparam int CLK_PERIOD      = 8;
    localparam int RESET_CYCLES    = 11;
    localparam int IDLE_PCT        = 31;
    localparam int RANDOM_ITEMS    = 1500;
    localparam int LONG_HOLD       = 400;
    localparam int NO_IDLE_FROM    = 700;
    localparam int NO_IDLE_TO      = 950;
    localparam int DRAIN_CYCLES    = 100;
    localparam int WATCHDOG_LIMIT  = 4000;
    localparam int DIRECTED_COUNT  = 25;

    localparam logic [CHAR_W-1:0]   CH_A   = 8'h61;
    localparam logic [CHAR_W-1:0]   CH_DOT = 8'h2E;
    localparam logic [WEIGHT_W-1:0] W_MAX  = {WEIGHT_W{1'b1}};

    logic                clk = 1'b0;
    logic                rst_n;
    logic                item_valid;
    logic                item_ready;
    logic [CMD_W-1:0]    command;
    logic [CHAR_W-1:0]   char_byte;
    logic [WEIGHT_W-1:0] weight;
    logic                result_valid;
    logic                result_ready;
    logic [TOTAL_W-1:0]  total;

    weighted_keyword_scorer_unit #(
        .MAX_KEYWORDS(MAX_KEYWORDS),
        .MAX_WORD_LEN(MAX_WORD_LEN)
    ) dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .item_valid  (item_valid),
        .item_ready  (item_ready),
        .command     (command),
        .char_byte   (char_byte),
        .weight      (weight),
        .result_valid(result_valid),
        .result_ready(result_ready),
        .total       (total)
    );

    always #(CLK_PERIOD / 2) clk = ~clk;

    // Directed stimulus: a typed total is used where it is obvious
    typedef struct packed {
        logic [CMD_W-1:0]    cmd;
        logic [CHAR_W-1:0]   ch;
        logic [WEIGHT_W-1:0] wt;
        logic                typed;
        logic [TOTAL_W-1:0]  total;
    } stim_row_t;

    stim_row_t directed_rows [DIRECTED_COUNT] = '{
        '{CMD_END,      8'h00,    24'h000000, 1'b1, 40'h0},
        '{CMD_KEY_BYTE, CH_A,     24'h000000, 1'b0, 40'h0},
        '{CMD_COMMIT,   8'h00,    W_MAX,      1'b0, 40'h0},
        '{CMD_KEY_BYTE, CH_DOT,   24'h000000, 1'b0, 40'h0},
        '{CMD_KEY_BYTE, 8'hFF,    24'h000000, 1'b0, 40'h0},
        '{CMD_COMMIT,   8'h00,    24'h000000, 1'b0, 40'h0},
        '{CMD_COMMIT,   8'h00,    24'h000001, 1'b0, 40'h0},
        '{CMD_TEXT,     CH_A,     24'h000000, 1'b0, 40'h0},
        '{CMD_TEXT,     CH_SPACE, 24'h000000, 1'b0, 40'h0},
        '{CMD_TEXT,     CH_SPACE, 24'h000000, 1'b0, 40'h0},
        '{CMD_TEXT,     CH_DOT,   24'h000000, 1'b0, 40'h0},
        '{CMD_TEXT,     8'hFF,    24'h000000, 1'b0, 40'h0},
        '{CMD_TEXT,     CH_LF,    24'h000000, 1'b0, 40'h0},
        '{CMD_TEXT,     CH_LF,    24'h000000, 1'b0, 40'h0},
        '{CMD_END,      8'h00,    24'h000000, 1'b1, 40'h00_00FF_FFFF},
        '{CMD_TEXT,     CH_A,     24'h000000, 1'b0, 40'h0},
        '{CMD_END,      8'h00,    24'h000000, 1'b1, 40'h00_00FF_FFFF},
        '{CMD_END,      8'h00,    24'h000000, 1'b1, 40'h0},
        '{CMD_KEY_BYTE, CH_A,     24'h000000, 1'b0, 40'h0},
        '{CMD_TEXT,     CH_A,     24'h000000, 1'b0, 40'h0},
        '{CMD_COMMIT,   8'h00,    24'h000005, 1'b0, 40'h0},
        '{CMD_TEXT,     CH_A,     24'h000000, 1'b0, 40'h0},
        '{CMD_TEXT,     CH_A,     24'h000000, 1'b0, 40'h0},
        '{CMD_TEXT,     CH_LF,    24'h000000, 1'b0, 40'h0},
        '{CMD_END,      8'h00,    24'h000000, 1'b0, 40'h0}
    };

    // Scorer state mirrored on the testbench side
    logic [CHAR_W-1:0]   kw_chars [MAX_KEYWORDS][MAX_WORD_LEN];
    int                  kw_len [MAX_KEYWORDS];
    logic [WEIGHT_W-1:0] kw_weight [MAX_KEYWORDS];
    int                  kw_count = 0;
    logic [CHAR_W-1:0]   word_buf [MAX_WORD_LEN];
    int                  word_len = 0;
    bit                  word_long = 1'b0;
    logic [TOTAL_W-1:0]  running_score = '0;

    logic [TOTAL_W-1:0]  expected_totals [$];
    int                  items_sent = 0;
    int                  mismatches = 0;
    int                  quiet_edges = 0;
    bit                  no_idle = 1'b0;
    bit                  hold_results = 1'b0;

    // Close the text word: first exact table match adds its weight, saturating
    function automatic void close_word();
        bit                 same;
        logic [TOTAL_W:0]   grown;
        if (!word_long && word_len > 0)
        begin
            for (int k = 0; k < kw_count; k++)
            begin
                if (kw_len[k] == word_len)
                begin
                    same = 1'b1;
                    for (int i = 0; i < word_len; i++)
                        if (kw_chars[k][i] != word_buf[i])
                            same = 1'b0;
                    if (same)
                    begin
                        grown = {1'b0, running_score} + (TOTAL_W + 1)'(kw_weight[k]);
                        running_score = grown[TOTAL_W] ? '1 : grown[TOTAL_W-1:0];
                        break;
                    end
                end
            end
        end
        word_len  = 0;
        word_long = 1'b0;
    endfunction

    // Advance the mirrored state by one accepted word
    function automatic void score_item(input logic [CMD_W-1:0] cmd,
                                       input logic [CHAR_W-1:0] ch,
                                       input logic [WEIGHT_W-1:0] wt,
                                       output bit emits,
                                       output logic [TOTAL_W-1:0] score);
        emits = 1'b0;
        score = '0;
        case (cmd)
            CMD_KEY_BYTE:
            begin
                if (word_len < MAX_WORD_LEN)
                begin
                    word_buf[word_len] = ch;
                    word_len++;
                end
            end
            CMD_COMMIT:
            begin
                if (kw_count < MAX_KEYWORDS)
                begin
                    for (int i = 0; i < word_len; i++)
                        kw_chars[kw_count][i] = word_buf[i];
                    kw_len[kw_count]    = word_len;
                    kw_weight[kw_count] = wt;
                    kw_count++;
                end
                word_len  = 0;
                word_long = 1'b0;
            end
            CMD_TEXT:
            begin
                if (ch == CH_SPACE || ch == CH_LF)
                    close_word();
                else if (word_len < MAX_WORD_LEN)
                begin
                    word_buf[word_len] = ch;
                    word_len++;
                end
                else
                    word_long = 1'b1;
            end
            default:
            begin
                close_word();
                emits         = 1'b1;
                score         = running_score;
                running_score = '0;
            end
        endcase
    endfunction

    function automatic logic [CHAR_W-1:0] pick_letter();
        int n;
        n = $urandom_range(0, 3);
        return (n == 3) ? CH_DOT : CH_A + CHAR_W'(n);
    endfunction

    // Offer one word, hold it until taken, then record the expected total
    task automatic send_item(input logic [CMD_W-1:0] cmd,
                             input logic [CHAR_W-1:0] ch,
                             input logic [WEIGHT_W-1:0] wt,
                             input bit typed,
                             input logic [TOTAL_W-1:0] typed_total);
        bit                 emits;
        logic [TOTAL_W-1:0] predicted;
        while (!no_idle && $urandom_range(0, 99) < IDLE_PCT)
        begin
            item_valid <= 1'b0;
            @(posedge clk);
        end
        item_valid <= 1'b1;
        command    <= cmd;
        char_byte  <= ch;
        weight     <= wt;
        @(posedge clk);
        while (!item_ready)
            @(posedge clk);
        score_item(cmd, ch, wt, emits, predicted);
        if (emits)
            expected_totals.push_back(typed ? typed_total : predicted);
        items_sent++;
    endtask

    // Stimulus: directed rows, then a random mix with one stretch free of idling
    initial
    begin : stimulus
        int                 r;
        int                 n;
        int                 k;
        int                 len;
        int                 key_pct;
        logic [WEIGHT_W-1:0] wt;
        logic [CHAR_W-1:0]  word_bytes [$];

        rst_n      <= 1'b0;
        item_valid <= 1'b0;
        command    <= CMD_KEY_BYTE;
        char_byte  <= '0;
        weight     <= '0;
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed_rows[i])
            send_item(directed_rows[i].cmd, directed_rows[i].ch, directed_rows[i].wt,
                      directed_rows[i].typed, directed_rows[i].total);

        // Stall the receiver once while a case end goes in
        hold_results = 1'b1;
        send_item(CMD_END, 8'($urandom), 24'($urandom), 1'b0, '0);

        while (items_sent < DIRECTED_COUNT + RANDOM_ITEMS)
        begin
            no_idle = (items_sent >= NO_IDLE_FROM) && (items_sent < NO_IDLE_TO);
            r = $urandom_range(0, 99);
            key_pct = (kw_count < MAX_KEYWORDS) ? 30 : 8;
            word_bytes.delete();
            if (r < key_pct)
            begin
                // Load a keyword, sometimes empty or past the length limit
                n = $urandom_range(0, 99);
                if (n < 5)
                    len = 0;
                else if (n < 75)
                    len = $urandom_range(1, 4);
                else
                    len = $urandom_range(1, MAX_WORD_LEN + 4);
                for (int i = 0; i < len; i++)
                    send_item(CMD_KEY_BYTE,
                              (n < 75) ? pick_letter() : CHAR_W'($urandom_range(0, 255)),
                              24'($urandom), 1'b0, '0);
                n = $urandom_range(0, 99);
                wt = (n < 10) ? W_MAX : (n < 15) ? '0 : 24'($urandom);
                send_item(CMD_COMMIT, 8'($urandom), wt, 1'b0, '0);
            end
            else if (r < key_pct + 55)
            begin
                // Build a text word, mostly a stored keyword or a near miss
                n = $urandom_range(0, 99);
                if (kw_count > 0 && n < 50)
                begin
                    k = $urandom_range(0, kw_count - 1);
                    for (int i = 0; i < kw_len[k]; i++)
                        word_bytes.push_back(kw_chars[k][i]);
                    n = $urandom_range(0, 99);
                    if (n < 15)
                        repeat ($urandom_range(1, 3)) word_bytes.push_back(pick_letter());
                    else if (n < 25 && word_bytes.size() > 0)
                        void'(word_bytes.pop_back());
                end
                else if (n < 85)
                    repeat ($urandom_range(1, 3)) word_bytes.push_back(pick_letter());
                else
                    repeat ($urandom_range(1, MAX_WORD_LEN + 4))
                        word_bytes.push_back(CHAR_W'($urandom_range(0, 255)));
                foreach (word_bytes[i])
                    send_item(CMD_TEXT, word_bytes[i], 24'($urandom), 1'b0, '0);
                repeat ($urandom_range(1, 2))
                    send_item(CMD_TEXT, ($urandom_range(0, 1) != 0) ? CH_SPACE : CH_LF,
                              24'($urandom), 1'b0, '0);
            end
            else if (r < key_pct + 64)
                send_item(CMD_END, 8'($urandom), 24'($urandom), 1'b0, '0);
            else
                repeat ($urandom_range(1, 3))
                    send_item(CMD_W'($urandom_range(0, 3)), CHAR_W'($urandom_range(0, 255)),
                              24'($urandom), 1'b0, '0);
        end

        // Close the last case
        no_idle = 1'b0;
        send_item(CMD_END, 8'h00, '0, 1'b0, '0);
        item_valid <= 1'b0;

        while (expected_totals.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (mismatches == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

    // Drive result_ready: random stalls, one long hold-off
    initial
    begin : result_side
        bit long_hold_done;
        long_hold_done = 1'b0;
        result_ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_results && !long_hold_done)
            begin
                long_hold_done = 1'b1;
                result_ready <= 1'b0;
                repeat (LONG_HOLD) @(posedge clk);
            end
            else
                result_ready <= rst_n && (no_idle || $urandom_range(0, 99) >= IDLE_PCT);
        end
    end

    // Check each taken total against the oldest expectation
    always @(posedge clk)
    begin : check_totals
        logic [TOTAL_W-1:0] want;
        if (rst_n && result_valid && result_ready)
        begin
            if (expected_totals.size() == 0)
            begin
                $error("total: expected none, got %0h", total);
                mismatches++;
            end
            else
            begin
                want = expected_totals.pop_front();
                if (total !== want)
                begin
                    $error("total: expected %0h, got %0h", want, total);
                    mismatches++;
                end
            end
        end
    end

    // Drop the run if neither channel moves for too long
    always @(posedge clk)
    begin
        if (!rst_n || (item_valid && item_ready) || (result_valid && result_ready))
            quiet_edges <= 0;
        else
        begin
            quiet_edges <= quiet_edges + 1;
            if (quiet_edges == WATCHDOG_LIMIT)
            begin
                $display("end of test: mismatches");
                $finish;
            end
        end
    end

endmodule
`default_nettype wire

[filelist.f]
hw/rtl/wks_pkg.sv
hw/rtl/wks_front.sv
hw/rtl/wks_queue.sv
hw/rtl/wks_back.sv
hw/rtl/weighted_keyword_scorer_unit.sv
tb/tb.sv
